// File: rtl/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// shared types and constants of the associated legendre evaluator
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int unsigned MAX_DEGREE = 63;
  localparam int unsigned DEG_W      = 6;
  localparam int unsigned ARG_W      = 32;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned IN_DATA_W  = 48;

  // operand selection for the arithmetic units
  typedef enum logic [3:0] {
    SRC_NONE,
    SRC_XX,
    SRC_TS,
    SRC_P2X,
    SRC_UC,
    SRC_P1X,
    SRC_P2R,
    SRC_DT,
    SRC_DC0,
    SRC_DC,
    SRC_DR,
    SRC_QT,
    SRC_QQ
  } src_t;

  // write-back target for a finished unit result
  typedef enum logic [3:0] {
    DST_NONE,
    DST_S,
    DST_TM,
    DST_TD,
    DST_P2,
    DST_Q,
    DST_C,
    DST_R,
    DST_U,
    DST_P1F,
    DST_STEP
  } dst_t;

  typedef struct packed {
    logic load;
    logic mul_go;
    logic div_go;
    logic sqrt_go;
    src_t src;
    logic wb;
    dst_t dst;
    logic zero_p;
    logic out_load;
  } ale_cmd_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic k_gt;
    logic i_gt;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
  } ale_sts_t;

endpackage

// File: rtl/ale_dp.sv
// ----------------------------------------------------------------------------
// ale_dp
// datapath: working registers, sequential multiplier, divider and square root
// ----------------------------------------------------------------------------
module ale_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ale_pkg::ale_cmd_t             cmd,
  output ale_pkg::ale_sts_t             sts,
  input  logic [ale_pkg::DEG_W-1:0]     in_degree,
  input  logic [ale_pkg::DEG_W-1:0]     in_order,
  input  logic signed [ale_pkg::ARG_W-1:0] in_argument,
  output logic [ale_pkg::VAL_W-1:0]     out_value
);

  localparam logic signed [47:0] TERM_MAX = 48'sh7F_FFFF_FFFF;
  localparam logic signed [31:0] ONE_Q30  = 32'sh4000_0000;

  function automatic logic signed [47:0] sat_term(input logic signed [48:0] v);
    if (v > 49'(TERM_MAX)) begin
      sat_term = TERM_MAX;
    end else if (v < -49'(TERM_MAX)) begin
      sat_term = -TERM_MAX;
    end else begin
      sat_term = v[47:0];
    end
  endfunction

  // working registers
  logic [5:0]         l_r, m_r;
  logic signed [31:0] x_r;
  logic [30:0]        s_r;
  logic [33:0]        t_r;
  logic [6:0]         k_r, i_r;
  logic [31:0]        c_r, r_r;
  logic [63:0]        q_r;
  logic signed [47:0] u_r, p_r, p1_r, p2_r;
  logic [31:0]        out_value_r;

  // multiplier
  logic [47:0]  ma_r;
  logic [33:0]  mb_r;
  logic         msh30_r, mneg_r;
  logic [81:0]  acc_r;
  logic [1:0]   mcnt_r;
  logic         mbusy_r, mdone_r;
  logic signed [47:0] ma_sel;
  logic signed [33:0] mb_sel;
  logic         msh_sel;
  logic [15:0]  chunk;
  logic [49:0]  pp;
  logic [47:0]  mres_mag;
  logic signed [47:0] mres;

  // divider
  logic [77:0]  dv_r;
  logic [25:0]  dden_r, drem_r;
  logic [63:0]  quo_r;
  logic [6:0]   dcnt_r;
  logic         dbusy_r, ddone_r;
  logic [77:0]  dv_sel;
  logic [25:0]  dden_sel;
  logic [26:0]  dtrial;
  logic         dge;

  // square root
  logic [63:0]  sv_r;
  logic [33:0]  srem_r;
  logic [31:0]  root_r;
  logic [4:0]   scnt_r;
  logic         sbusy_r, sdone_r;
  logic [35:0]  sremt, strial;
  logic         sge;

  // recurrence coefficients
  logic [6:0]   im1;
  logic [13:0]  isq, im1sq;
  logic [11:0]  msq;
  logic [15:0]  n_cur, n_prev;
  logic [13:0]  d_cur, d_prev;
  logic [29:0]  num_r_w, den_r_w;
  logic [41:0]  t_div;
  logic signed [48:0] step_diff;
  logic signed [47:0] step_val, p1_val;
  logic [47:0]  p_mag;
  logic [42:0]  out_mag;
  logic signed [43:0] out_s;

  assign im1     = i_r - 7'd1;
  assign isq     = 14'(i_r) * 14'(i_r);
  assign im1sq   = 14'(im1) * 14'(im1);
  assign msq     = 12'(m_r) * 12'(m_r);
  assign n_cur   = 16'({isq, 2'b00} - 16'd1);
  assign n_prev  = 16'({im1sq, 2'b00} - 16'd1);
  assign d_cur   = isq - 14'(msq);
  assign d_prev  = im1sq - 14'(msq);
  assign num_r_w = 30'(n_cur) * 30'(d_prev);
  assign den_r_w = 30'(d_cur) * 30'(n_prev);
  assign t_div   = 42'(t_r) * 42'({k_r, 1'b1}) + 42'(k_r);

  // multiplier operand select
  always_comb begin
    ma_sel  = '0;
    mb_sel  = '0;
    msh_sel = 1'b1;
    case (cmd.src)
      ale_pkg::SRC_XX:  begin ma_sel = 48'(x_r);  mb_sel = 34'(x_r); end
      ale_pkg::SRC_TS:  begin ma_sel = $signed(48'(t_r)); mb_sel = $signed(34'(s_r)); end
      ale_pkg::SRC_P2X: begin ma_sel = p2_r; mb_sel = 34'(x_r); end
      ale_pkg::SRC_P1X: begin ma_sel = p1_r; mb_sel = 34'(x_r); end
      ale_pkg::SRC_UC:  begin
        ma_sel = u_r; mb_sel = $signed(34'(c_r)); msh_sel = 1'b0;
      end
      ale_pkg::SRC_P2R: begin
        ma_sel = p2_r; mb_sel = $signed(34'(r_r)); msh_sel = 1'b0;
      end
      default: ;
    endcase
  end

  assign chunk    = ma_r[{mcnt_r, 4'b0000} +: 16];
  assign pp       = chunk * mb_r;
  assign mres_mag = msh30_r ? 48'((acc_r + (82'd1 << 29)) >> 30)
                            : 48'((acc_r + (82'd1 << 25)) >> 26);
  assign mres     = mneg_r ? -$signed(mres_mag) : $signed(mres_mag);

  // divider operand select
  always_comb begin
    dv_sel   = '0;
    dden_sel = 26'd1;
    case (cmd.src)
      ale_pkg::SRC_DT:  begin dv_sel = 78'(t_div); dden_sel = 26'({k_r, 1'b0}); end
      ale_pkg::SRC_DC0: begin dv_sel = {26'({m_r, 1'b1}) + 26'd2, 52'b0}; end
      ale_pkg::SRC_DC:  begin dv_sel = {26'(n_cur), 52'b0}; dden_sel = 26'(d_cur); end
      ale_pkg::SRC_DR:  begin dv_sel = {num_r_w[25:0], 52'b0}; dden_sel = den_r_w[25:0]; end
      default: ;
    endcase
  end

  assign dtrial = {drem_r, dv_r[77]};
  assign dge    = dtrial >= {1'b0, dden_r};

  assign sremt  = {srem_r, sv_r[63:62]};
  assign strial = {2'b00, root_r, 2'b01};
  assign sge    = sremt >= strial;

  assign step_diff = 49'(u_r) - 49'(mres);
  assign step_val  = sat_term(step_diff);
  assign p1_val    = sat_term(49'(mres));

  // output rounding to q8.24
  assign p_mag   = p_r[47] ? 48'(-p_r) : 48'(p_r);
  assign out_mag = 43'((p_mag + 48'd32) >> 6);
  assign out_s   = p_r[47] ? -$signed({1'b0, out_mag}) : $signed({1'b0, out_mag});

  // unit control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mbusy_r <= 1'b0; mdone_r <= 1'b0; mcnt_r <= '0;
      dbusy_r <= 1'b0; ddone_r <= 1'b0; dcnt_r <= '0;
      sbusy_r <= 1'b0; sdone_r <= 1'b0; scnt_r <= '0;
    end else begin
      mdone_r <= 1'b0;
      ddone_r <= 1'b0;
      sdone_r <= 1'b0;
      if (cmd.mul_go) begin
        mbusy_r <= 1'b1; mcnt_r <= '0;
      end else if (mbusy_r) begin
        mcnt_r <= mcnt_r + 2'd1;
        if (mcnt_r == 2'd2) begin
          mbusy_r <= 1'b0; mdone_r <= 1'b1;
        end
      end
      if (cmd.div_go) begin
        dbusy_r <= 1'b1; dcnt_r <= '0;
      end else if (dbusy_r) begin
        dcnt_r <= dcnt_r + 7'd1;
        if (dcnt_r == 7'd77) begin
          dbusy_r <= 1'b0; ddone_r <= 1'b1;
        end
      end
      if (cmd.sqrt_go) begin
        sbusy_r <= 1'b1; scnt_r <= '0;
      end else if (sbusy_r) begin
        scnt_r <= scnt_r + 5'd1;
        if (scnt_r == 5'd31) begin
          sbusy_r <= 1'b0; sdone_r <= 1'b1;
        end
      end
    end
  end

  // unit payload
  always_ff @(posedge clk) begin
    if (cmd.mul_go) begin
      ma_r    <= ma_sel[47] ? 48'(-ma_sel) : 48'(ma_sel);
      mb_r    <= mb_sel[33] ? 34'(-mb_sel) : 34'(mb_sel);
      mneg_r  <= ma_sel[47] ^ mb_sel[33];
      msh30_r <= msh_sel;
      acc_r   <= '0;
    end else if (mbusy_r) begin
      acc_r <= acc_r + (82'(pp) << {mcnt_r, 4'b0000});
    end
    if (cmd.div_go) begin
      dv_r   <= dv_sel;
      dden_r <= dden_sel;
      drem_r <= '0;
      quo_r  <= '0;
    end else if (dbusy_r) begin
      dv_r   <= {dv_r[76:0], 1'b0};
      drem_r <= dge ? 26'(dtrial - {1'b0, dden_r}) : dtrial[25:0];
      quo_r  <= {quo_r[62:0], dge};
    end
    if (cmd.sqrt_go) begin
      sv_r   <= (cmd.src == ale_pkg::SRC_QT) ? {t_r, 30'b0} : q_r;
      srem_r <= '0;
      root_r <= '0;
    end else if (sbusy_r) begin
      sv_r   <= {sv_r[61:0], 2'b00};
      srem_r <= sge ? 34'(sremt - strial) : sremt[33:0];
      root_r <= {root_r[30:0], sge};
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      l_r <= (in_degree > 6'(ale_pkg::MAX_DEGREE)) ? 6'(ale_pkg::MAX_DEGREE) : in_degree;
      m_r <= (in_order > 6'(ale_pkg::MAX_DEGREE)) ? 6'(ale_pkg::MAX_DEGREE) : in_order;
      if (in_argument > ONE_Q30) begin
        x_r <= ONE_Q30;
      end else if (in_argument < -ONE_Q30) begin
        x_r <= -ONE_Q30;
      end else begin
        x_r <= in_argument;
      end
    end
    if (cmd.zero_p) begin
      p_r <= '0;
    end
    if (cmd.wb) begin
      case (cmd.dst)
        ale_pkg::DST_S: begin
          s_r <= 31'h4000_0000 - mres[30:0];
          t_r <= 34'h2000_0000;
          k_r <= 7'd1;
        end
        ale_pkg::DST_TM: t_r <= mres[33:0];
        ale_pkg::DST_TD: begin
          t_r <= quo_r[33:0];
          k_r <= k_r + 7'd1;
        end
        ale_pkg::DST_P2: begin
          p2_r <= $signed(48'(root_r));
          p_r  <= $signed(48'(root_r));
        end
        ale_pkg::DST_Q: q_r <= quo_r;
        ale_pkg::DST_C: c_r <= root_r;
        ale_pkg::DST_R: r_r <= root_r;
        ale_pkg::DST_U: u_r <= mres;
        ale_pkg::DST_P1F: begin
          p1_r <= p1_val;
          p_r  <= p1_val;
          i_r  <= 7'(m_r) + 7'd2;
        end
        ale_pkg::DST_STEP: begin
          p_r  <= step_val;
          p1_r <= step_val;
          p2_r <= p1_r;
          i_r  <= i_r + 7'd1;
        end
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      if (out_s > 44'sh0_7FFF_FFFF) begin
        out_value_r <= 32'h7FFF_FFFF;
      end else if (out_s < -44'sh0_8000_0000) begin
        out_value_r <= 32'h8000_0000;
      end else begin
        out_value_r <= out_s[31:0];
      end
    end
  end

  assign out_value     = out_value_r;
  assign sts.lt        = l_r < m_r;
  assign sts.eq        = l_r == m_r;
  assign sts.k_gt      = k_r > {1'b0, m_r};
  assign sts.i_gt      = i_r > {1'b0, l_r};
  assign sts.mul_done  = mdone_r;
  assign sts.div_done  = ddone_r;
  assign sts.sqrt_done = sdone_r;

endmodule

// File: rtl/ale_ctrl.sv
// ----------------------------------------------------------------------------
// ale_ctrl
// sequencer: start product loop, square roots and upward recurrence
// ----------------------------------------------------------------------------
module ale_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output ale_pkg::ale_cmd_t cmd,
  input  ale_pkg::ale_sts_t sts
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_CHK, ST_XX, ST_KCHK, ST_TS, ST_TD, ST_SQT, ST_C0D, ST_C0S,
    ST_P2X, ST_UC0, ST_ICHK, ST_CD, ST_CS, ST_RD, ST_RS, ST_P1X, ST_UC,
    ST_P2R, ST_FIN
  } state_t;

  typedef enum logic [1:0] {U_NONE, U_MUL, U_DIV, U_SQRT} unit_t;

  state_t        state_r, state_nxt, after;
  logic          phase_r, phase_nxt;
  logic          out_valid_r, out_valid_nxt;
  unit_t         unit;
  ale_pkg::src_t src;
  ale_pkg::dst_t dst;
  logic          unit_done;

  // per-state unit call
  always_comb begin
    unit  = U_NONE;
    src   = ale_pkg::SRC_NONE;
    dst   = ale_pkg::DST_NONE;
    after = ST_IDLE;
    case (state_r)
      ST_XX:  begin unit = U_MUL;  src = ale_pkg::SRC_XX;  dst = ale_pkg::DST_S;   after = ST_KCHK; end
      ST_TS:  begin unit = U_MUL;  src = ale_pkg::SRC_TS;  dst = ale_pkg::DST_TM;  after = ST_TD;   end
      ST_TD:  begin unit = U_DIV;  src = ale_pkg::SRC_DT;  dst = ale_pkg::DST_TD;  after = ST_KCHK; end
      ST_SQT: begin
        unit = U_SQRT; src = ale_pkg::SRC_QT; dst = ale_pkg::DST_P2;
        after = sts.eq ? ST_FIN : ST_C0D;
      end
      ST_C0D: begin unit = U_DIV;  src = ale_pkg::SRC_DC0; dst = ale_pkg::DST_Q;   after = ST_C0S;  end
      ST_C0S: begin unit = U_SQRT; src = ale_pkg::SRC_QQ;  dst = ale_pkg::DST_C;   after = ST_P2X;  end
      ST_P2X: begin unit = U_MUL;  src = ale_pkg::SRC_P2X; dst = ale_pkg::DST_U;   after = ST_UC0;  end
      ST_UC0: begin unit = U_MUL;  src = ale_pkg::SRC_UC;  dst = ale_pkg::DST_P1F; after = ST_ICHK; end
      ST_CD:  begin unit = U_DIV;  src = ale_pkg::SRC_DC;  dst = ale_pkg::DST_Q;   after = ST_CS;   end
      ST_CS:  begin unit = U_SQRT; src = ale_pkg::SRC_QQ;  dst = ale_pkg::DST_C;   after = ST_RD;   end
      ST_RD:  begin unit = U_DIV;  src = ale_pkg::SRC_DR;  dst = ale_pkg::DST_Q;   after = ST_RS;   end
      ST_RS:  begin unit = U_SQRT; src = ale_pkg::SRC_QQ;  dst = ale_pkg::DST_R;   after = ST_P1X;  end
      ST_P1X: begin unit = U_MUL;  src = ale_pkg::SRC_P1X; dst = ale_pkg::DST_U;   after = ST_UC;   end
      ST_UC:  begin unit = U_MUL;  src = ale_pkg::SRC_UC;  dst = ale_pkg::DST_U;   after = ST_P2R;  end
      ST_P2R: begin unit = U_MUL;  src = ale_pkg::SRC_P2R; dst = ale_pkg::DST_STEP; after = ST_ICHK; end
      default: ;
    endcase
  end

  always_comb begin
    case (unit)
      U_MUL:   unit_done = sts.mul_done;
      U_DIV:   unit_done = sts.div_done;
      U_SQRT:  unit_done = sts.sqrt_done;
      default: unit_done = 1'b0;
    endcase
  end

  always_comb begin
    cmd           = '0;
    state_nxt     = state_r;
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r && !out_tready;
    if (unit != U_NONE) begin
      if (!phase_r) begin
        cmd.mul_go  = (unit == U_MUL);
        cmd.div_go  = (unit == U_DIV);
        cmd.sqrt_go = (unit == U_SQRT);
        cmd.src     = src;
        phase_nxt   = 1'b1;
      end else if (unit_done) begin
        cmd.wb    = 1'b1;
        cmd.dst   = dst;
        phase_nxt = 1'b0;
        state_nxt = after;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_tvalid) begin
            cmd.load  = 1'b1;
            state_nxt = ST_CHK;
          end
        end
        ST_CHK: begin
          if (sts.lt) begin
            cmd.zero_p = 1'b1;
            state_nxt  = ST_FIN;
          end else begin
            state_nxt = ST_XX;
          end
        end
        ST_KCHK: state_nxt = sts.k_gt ? ST_SQT : ST_TS;
        ST_ICHK: state_nxt = sts.i_gt ? ST_FIN : ST_CD;
        ST_FIN: begin
          if (!out_valid_r || out_tready) begin
            cmd.out_load  = 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;

endmodule

// File: rtl/associated_legendre_eval.sv
// ----------------------------------------------------------------------------
// associated_legendre_eval
// unity-norm associated legendre value from degree, order and argument
// ----------------------------------------------------------------------------
// usage:
//   in channel carries one request per transfer: degree, order and the
//   argument x (signed q1.30, clamped to [-1,1]); out channel returns one
//   signed q8.24 value per request, saturated.
//   one request is worked at a time; in_tready is high only while idle.
//   the run time covers the start product (growing with m), its square
//   root, the first recurrence term and each further degree step (l-m-1
//   of them). the bit-serial divider and the square root, used twice
//   each per recurrence step, dominate it.
//   order above degree returns zero.
//   the result sits in an output register; a stalled receiver does not stop
//   the next request from being taken, only its completion waits.
//   reset (rst_n low, synchronous) returns to idle and drops out_tvalid.
// ----------------------------------------------------------------------------
module associated_legendre_eval (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // degree [5:0], order [11:6], argument [43:12], zero pad [47:44]
  input  logic [ale_pkg::IN_DATA_W-1:0]    in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // value [31:0]
  output logic [ale_pkg::VAL_W-1:0]        out_tdata
);

  ale_pkg::ale_cmd_t cmd;
  ale_pkg::ale_sts_t sts;

  // sequencer
  ale_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // arithmetic and working registers
  ale_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_degree   (in_tdata[5:0]),
    .in_order    (in_tdata[11:6]),
    .in_argument ($signed(in_tdata[43:12])),
    .out_value   (out_tdata)
  );

endmodule

// File: bench/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the associated legendre evaluator
// ----------------------------------------------------------------------------
// requests go in as bursts with random gaps, the receiver stalls on its own
// pattern, and every value returned is checked against a bit-exact fixed
// point model of the evaluator held in the bench.
// ----------------------------------------------------------------------------
module testbench;

  localparam longint ONE_Q30  = 64'sd1 << 30;
  localparam longint TERM_LIM = (64'sd1 << 39) - 1;

  logic                          clk;
  logic                          rst_n;
  logic                          in_tvalid;
  logic                          in_tready;
  // degree [5:0], order [11:6], argument [43:12], zero pad [47:44]
  logic [ale_pkg::IN_DATA_W-1:0] in_tdata;
  logic                          out_tvalid;
  logic                          out_tready;
  // value [31:0]
  logic [ale_pkg::VAL_W-1:0]     out_tdata;

  logic [ale_pkg::VAL_W-1:0] legendre_q[$];
  int                        mismatches;
  int                        checked;
  bit                        stall_on;

  associated_legendre_eval dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------- model
  function automatic longint unsigned magn(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // product scaled down by 2^sh, rounded half away from zero
  function automatic longint mul_round(longint a, longint b, int sh);
    bit               neg;
    longint unsigned ua, ub, hi, lo, r;
    neg = (a < 0) != (b < 0);
    ua  = magn(a);
    ub  = magn(b);
    hi  = ua >> sh;
    lo  = ua & ((64'd1 << sh) - 1);
    r   = hi * ub + ((lo * ub + (64'd1 << (sh - 1))) >> sh);
    return neg ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv >>= 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v  -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // sqrt(num/den) in q.26, quotient formed with 52 fraction bits
  function automatic longint sqrt_ratio(longint unsigned num, longint unsigned den);
    longint unsigned acc, rem;
    acc = num / den;
    rem = num % den;
    for (int k = 0; k < 52; k++) begin
      rem <<= 1;
      acc <<= 1;
      if (rem >= den) begin
        rem -= den;
        acc |= 1;
      end
    end
    return longint'(int_sqrt(acc));
  endfunction

  function automatic longint clip_term(longint v);
    if (v > TERM_LIM) return TERM_LIM;
    if (v < -TERM_LIM) return -TERM_LIM;
    return v;
  endfunction

  function automatic logic [ale_pkg::VAL_W-1:0] legendre_value(logic [5:0] deg,
                                                               logic [5:0] ord,
                                                               logic [31:0] arg);
    longint unsigned l, m, mm, mg, ncur, dcur, nprev, dprev;
    longint x, s, t, p, p1, p2, c, r, v;
    l = deg;
    m = ord;
    p = 0;
    if (l > ale_pkg::MAX_DEGREE) l = ale_pkg::MAX_DEGREE;
    if (m > ale_pkg::MAX_DEGREE) m = ale_pkg::MAX_DEGREE;
    x = longint'($signed(arg));
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    if (l >= m) begin
      s = ONE_Q30 - mul_round(x, x, 30);
      t = ONE_Q30 / 2;
      for (longint unsigned k = 1; k <= m; k++) begin
        t = mul_round(t, s, 30);
        t = longint'((longint'(t) * (2 * k + 1) + k) / (2 * k));
      end
      p2 = longint'(int_sqrt(longint'(t) << 30));
      if (l == m) begin
        p = p2;
      end else begin
        p1 = clip_term(mul_round(mul_round(p2, x, 30), sqrt_ratio(2 * m + 3, 1), 26));
        p  = p1;
        mm = m * m;
        for (longint unsigned i = m + 2; i <= l; i++) begin
          ncur  = 4 * i * i - 1;
          dcur  = i * i - mm;
          nprev = 4 * (i - 1) * (i - 1) - 1;
          dprev = (i - 1) * (i - 1) - mm;
          c = sqrt_ratio(ncur, dcur);
          r = sqrt_ratio(ncur * dprev, dcur * nprev);
          p = clip_term(mul_round(mul_round(p1, x, 30), c, 26) - mul_round(p2, r, 26));
          p2 = p1;
          p1 = p;
        end
      end
    end
    mg = (magn(p) + 32) >> 6;
    v  = (p < 0) ? -longint'(mg) : longint'(mg);
    if (v > 64'sd2147483647) v = 64'sd2147483647;
    if (v < -64'sd2147483648) v = -64'sd2147483648;
    return v[31:0];
  endfunction

  // ---------------------------------------------------------------- driving
  int burst_left;

  // one request transfer, with random gaps between bursts
  task automatic send_request(logic [5:0] deg, logic [5:0] ord, logic [31:0] arg);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 6);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0, arg, ord, deg};
    legendre_q.push_back(legendre_value(deg, ord, arg));
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // most degrees small so that the run stays short, a few near the top
  function automatic logic [5:0] pick_degree();
    if ($urandom_range(0, 9) == 0) return 6'($urandom_range(40, 63));
    return 6'($urandom_range(0, 12));
  endfunction

  function automatic logic [31:0] pick_arg();
    case ($urandom_range(0, 5))
      0:       return $urandom;
      1:       return $urandom_range(0, 2) == 0 ? 32'h4000_0000 : 32'hC000_0000;
      default: return 32'($signed($urandom_range(0, 32'h7FFF_FFFF)) % 32'sh4000_0001)
                      * ($urandom_range(0, 1) ? 1 : -1);
    endcase
  endfunction

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (legendre_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_field_extremes();
    send_request(6'd0, 6'd0, 32'h0000_0000);
    send_request(6'd0, 6'd0, 32'h4000_0000);
    send_request(6'd63, 6'd63, 32'h0000_0000);
    send_request(6'd63, 6'd0, 32'h4000_0000);
    send_request(6'd63, 6'd0, 32'hC000_0000);
    send_request(6'd63, 6'd62, 32'h2000_0000);
    send_request(6'd1, 6'd0, 32'hE000_0000);
    send_request(6'd5, 6'd3, 32'h3FFF_FFFF);
    send_request(6'd2, 6'd1, 32'h0000_0001);
    send_request(6'd20, 6'd20, 32'h1234_5678);
  endtask

  // order above degree returns zero
  task automatic test_order_above_degree();
    send_request(6'd0, 6'd63, 32'h1000_0000);
    send_request(6'd3, 6'd4, 32'hF000_0000);
    send_request(6'd62, 6'd63, 32'hFFFF_FFFF);
  endtask

  // argument outside [-1,1] clamps
  task automatic test_arg_clamp();
    send_request(6'd4, 6'd1, 32'h7FFF_FFFF);
    send_request(6'd4, 6'd1, 32'h8000_0000);
    send_request(6'd7, 6'd2, 32'h4000_0001);
    send_request(6'd7, 6'd2, 32'hBFFF_FFFF);
    send_request(6'd10, 6'd0, 32'hAAAA_AAAA);
    send_request(6'd10, 6'd9, 32'h5555_5555);
  endtask

  task automatic test_random_mix(int count);
    logic [5:0] deg, ord;
    for (int n = 0; n < count; n++) begin
      deg = pick_degree();
      ord = ($urandom_range(0, 7) == 0) ? 6'($urandom) : 6'($urandom_range(0, deg));
      send_request(deg, ord, pick_arg());
      if (n == count / 2) wait_drained();  // sender holds off until all values are back
    end
  endtask

  // ---------------------------------------------------------------- checking
  // receiver stall pattern, with stall-free stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      stall_on   <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      out_tready <= stall_on ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (legendre_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected value %h", out_tdata);
      end else begin
        logic [ale_pkg::VAL_W-1:0] want;
        want = legendre_q.pop_front();
        checked++;
        if (want !== out_tdata) begin
          mismatches++;
          if (mismatches <= 10)
            $display("value mismatch: expected %h actual %h", want, out_tdata);
        end
      end
    end
  end

  // ---------------------------------------------------------------- sequence
  initial begin
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    mismatches = 0;
    checked    = 0;
    burst_left = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_field_extremes();
    test_order_above_degree();
    test_arg_clamp();
    test_random_mix(121);
    wait_drained();
    if (mismatches == 0 && legendre_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // time limit for the whole run, set for worst-case requests and a stalled receiver
  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
